>>> rtl/core/bhm_pkg.sv
package bhm_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [2:0] REG_TEMPLATES_A  = 3'd2;
	localparam logic [2:0] REG_TEMPLATES_B  = 3'd3;
	localparam logic [2:0] REG_TEMPLATES_C  = 3'd4;
	localparam logic [2:0] REG_TEMPLATES_D  = 3'd5;

	localparam int CFG_W   = 36;
	localparam int IDX_W   = 3;
	localparam int IW_W    = 11;
	localparam int IH_W    = 12;
	localparam int CMP_W   = 13;  // wide enough for any column or line count plus one
	localparam int TPL_W   = 18;  // 9 care bits, then 9 value bits
	localparam int WIN_W   = 9;

	typedef logic [3:0][CFG_W-1:0] tmpl_set_t;
	typedef logic [WIN_W-1:0]      win_t;

	localparam logic [IW_W-1:0]  RST_IMAGE_WIDTH  = 11'd640;
	localparam logic [IH_W-1:0]  RST_IMAGE_HEIGHT = 12'd480;
	localparam logic [CFG_W-1:0] RST_TEMPLATES_A  = 36'd62400507863;
	localparam logic [CFG_W-1:0] RST_TEMPLATES_B  = 36'd41438983037;
	localparam logic [CFG_W-1:0] RST_TEMPLATES_C  = 36'd6776436154;
	localparam logic [CFG_W-1:0] RST_TEMPLATES_D  = 36'd20450992315;

	// Neighbour masks, bit k = 3*(dy+1)+(dx+1)
	localparam win_t MASK_TOP_ROW   = 9'h007;
	localparam win_t MASK_BOT_ROW   = 9'h1C0;
	localparam win_t MASK_LEFT_COL  = 9'h049;
	localparam win_t MASK_RIGHT_COL = 9'h124;
	localparam win_t MASK_SHIFT     = 9'h0DB;

	localparam logic [7:0] PIX_HIT  = 8'd255;
	localparam logic [7:0] PIX_MISS = 8'd0;

endpackage

>>> rtl/core/bhm_ram.sv
module bhm_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old entry when the same address is written in that cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/bhm_match.sv
module bhm_match
	import bhm_pkg::*;
#(
	parameter int NUM_TEMPLATES = 8
) (
	input  win_t      window,
	input  win_t      in_img,
	input  tmpl_set_t tmpl,
	output logic      hit
);

	logic [NUM_TEMPLATES-1:0] hits;

	for (genvar t = 0; t < NUM_TEMPLATES; t++) begin : g_tpl
		localparam int R  = t >> 1;
		localparam int SH = (t & 1) * TPL_W;
		win_t care;
		win_t val;
		assign care    = tmpl[R][SH +: WIN_W];
		assign val     = tmpl[R][SH + WIN_W +: WIN_W];
		assign hits[t] = ((window ^ val) & care & in_img) == '0;
	end

	assign hit = |hits;

endmodule

>>> rtl/core/binary_hit_or_miss_3x3.sv
// Binary 3x3 hit-or-miss transform on a raster pixel stream. Each pixel
// counts as foreground when nonzero; the result for a pixel is 255 when any
// of the configured 3x3 ternary templates matches its neighbourhood (pixels
// outside the image are not checked), else 0, and m_tlast marks the result
// for the last pixel of the frame. The block takes one request per clock
// while its result queue has room and returns results in raster order: the
// result for a pixel needs the pixel one line below and one to the right, so
// it follows image_width + 1 later input requests. After the last pixel of a
// frame, send image_width + 1 requests with s_tuser high to flush the last
// line; a request with s_tuser high during the pixel phase is dropped. The
// two previous lines live in a single-port-write, registered-read line
// memory of MAX_WIDTH entries; that registered read sets the two-stage
// depth, and a write-to-read bypass keeps width-1 images at full rate. A
// three-entry result queue lets input keep flowing while the output side
// stalls. Change the size and template registers only while the block is idle.
module binary_hit_or_miss_3x3
	import bhm_pkg::*;
#(
	parameter int MAX_WIDTH     = 1024,
	parameter int NUM_TEMPLATES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	// input stream
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] pixel
	input  logic             s_tuser,   // [0] drain
	// result stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // [7:0] out_pixel
	output logic             m_tlast,   // frame_end
	// configuration writes
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);

	// ---------------- configuration registers ----------------
	logic [IW_W-1:0] image_width_q;
	logic [IH_W-1:0] image_height_q;
	tmpl_set_t       tmpl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= RST_IMAGE_WIDTH;
			image_height_q <= RST_IMAGE_HEIGHT;
			tmpl_q[0]      <= RST_TEMPLATES_A;
			tmpl_q[1]      <= RST_TEMPLATES_B;
			tmpl_q[2]      <= RST_TEMPLATES_C;
			tmpl_q[3]      <= RST_TEMPLATES_D;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[IW_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[IH_W-1:0];
				REG_TEMPLATES_A:  tmpl_q[0]      <= cfg_data;
				REG_TEMPLATES_B:  tmpl_q[1]      <= cfg_data;
				REG_TEMPLATES_C:  tmpl_q[2]      <= cfg_data;
				REG_TEMPLATES_D:  tmpl_q[3]      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective sizes: zero counts as one, width clamps to the line memory
	logic [CMP_W-1:0] eff_w;
	logic [CMP_W-1:0] eff_h;
	logic [CMP_W-1:0] w_ext;

	assign w_ext = CMP_W'(image_width_q);
	assign eff_w = (w_ext == '0) ? CMP_W'(1) : ((w_ext > MAX_W_C) ? MAX_W_C : w_ext);
	assign eff_h = (image_height_q == '0) ? CMP_W'(1) : CMP_W'(image_height_q);

	// ---------------- stage 0: counters and line memory read ----------------
	logic [CW-1:0]    in_col_q;
	logic [CMP_W-1:0] in_line_q;
	logic [CW-1:0]    out_col_q;
	logic [IH_W-1:0]  out_line_q;

	logic             acc;
	logic             draining;
	logic             ign;
	logic             take;
	logic             x_in;
	logic             emit;
	logic             last;
	logic             in_col_wrap;
	logic             out_col_end;
	logic             out_line_end;
	win_t             in_img;

	assign acc      = s_tvalid && s_tready;
	assign draining = in_line_q >= eff_h;
	assign ign      = !draining && s_tuser;
	assign take     = acc && !ign;
	// drain requests push background into the window
	assign x_in     = !draining && (s_tdata != '0);

	assign emit = (in_line_q >= CMP_W'(2)) || (in_line_q == CMP_W'(1) && in_col_q != '0);
	assign in_col_wrap  = (CMP_W'(in_col_q) + CMP_W'(1)) >= eff_w;
	assign out_col_end  = (CMP_W'(out_col_q) + CMP_W'(1)) >= eff_w;
	assign out_line_end = (CMP_W'(out_line_q) + CMP_W'(1)) >= eff_h;
	assign last         = out_line_end && out_col_end;

	// mask off neighbours that fall outside the image
	always_comb begin
		in_img = '1;
		if (out_line_q == '0) in_img = in_img & ~MASK_TOP_ROW;
		if (out_line_end)     in_img = in_img & ~MASK_BOT_ROW;
		if (out_col_q == '0)  in_img = in_img & ~MASK_LEFT_COL;
		if (out_col_end)      in_img = in_img & ~MASK_RIGHT_COL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_line_q  <= '0;
			out_col_q  <= '0;
			out_line_q <= '0;
		end else if (take) begin
			if (emit && last) begin
				// frame done: restart every counter
				in_col_q   <= '0;
				in_line_q  <= '0;
				out_col_q  <= '0;
				out_line_q <= '0;
			end else begin
				if (in_col_wrap) begin
					in_col_q  <= '0;
					in_line_q <= in_line_q + CMP_W'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
				if (emit) begin
					if (out_col_end) begin
						out_col_q  <= '0;
						out_line_q <= out_line_q + IH_W'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
		end
	end

	// ---------------- stage 1: window update, write back, match ----------------
	logic          v_s1;
	logic          emit_s1;
	logic          last_s1;
	logic          x_s1;
	logic [CW-1:0] col_s1;
	win_t          in_img_s1;
	logic          fwd_s1;
	logic          fwd_top_s1;
	logic          fwd_mid_s1;

	logic [1:0]    ram_rdata;
	logic          top;
	logic          mid;
	win_t          window_q;
	win_t          window_next;
	logic          hit;
	logic          push;

	// line memory: bit 1 holds the line two above, bit 0 the line above
	bhm_ram #(
		.WIDTH (2),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (v_s1),
		.waddr (col_s1),
		.wdata ({mid, x_s1}),
		.raddr (in_col_q),
		.rdata (ram_rdata)
	);

	// bypass the write that lands in the same cycle as the read of the same column
	assign top = fwd_s1 ? fwd_top_s1 : ram_rdata[1];
	assign mid = fwd_s1 ? fwd_mid_s1 : ram_rdata[0];

	assign window_next = ((window_q >> 1) & MASK_SHIFT) |
		{x_s1, 2'b00, mid, 2'b00, top, 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			emit_s1    <= emit;
			last_s1    <= last;
			x_s1       <= x_in;
			col_s1     <= in_col_q;
			in_img_s1  <= in_img;
			fwd_s1     <= v_s1 && (col_s1 == in_col_q);
			fwd_top_s1 <= mid;
			fwd_mid_s1 <= x_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (v_s1) begin
			window_q <= window_next;
		end
	end

	bhm_match #(
		.NUM_TEMPLATES (NUM_TEMPLATES)
	) u_match (
		.window (window_next),
		.in_img (in_img_s1),
		.tmpl   (tmpl_q),
		.hit    (hit)
	);

	assign push = v_s1 && emit_s1;

	// ---------------- result queue ----------------
	logic       fifo_hit_q  [3];
	logic       fifo_last_q [3];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = cnt_q != '0;
	assign m_tdata  = fifo_hit_q[rd_ptr_q] ? PIX_HIT : PIX_MISS;
	assign m_tlast  = fifo_last_q[rd_ptr_q];
	// reserve a slot for the result still in stage 1
	assign s_tready = (3'(cnt_q) + 3'(push)) <= 3'd2;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_hit_q[wr_ptr_q]  <= hit;
			fifo_last_q[wr_ptr_q] <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == 2'd2) ? 2'd0 : wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == 2'd2) ? 2'd0 : rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// ---------------- assertions ----------------
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (cnt_q < 2'd3))
		else $error("result queue overflow");

	a_bypass_same_column: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && $past(v_s1) && col_s1 == $past(col_s1)) |-> fwd_s1)
		else $error("back-to-back access to one column without bypass");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(take && emit && last) |=>
		(in_col_q == '0 && in_line_q == '0 && out_col_q == '0 && out_line_q == '0))
		else $error("counters not cleared after frame end");

endmodule

>>> dv/tb_binary_hit_or_miss_3x3.sv
module tb_binary_hit_or_miss_3x3;
	import bhm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W = 1024;

	// one expected result: the output pixel and its end-of-frame mark
	typedef struct packed {
		logic [7:0] pix;
		logic       last;
	} hom_result_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [7:0]       s_tdata;   // [7:0] pixel
	logic             s_tuser;   // [0] drain
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [7:0]       m_tdata;   // [7:0] out_pixel
	logic             m_tlast;   // frame_end
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	binary_hit_or_miss_3x3 i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 10 ns period: low half, then high half
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow of the transform: registers, line buffers, window, counters
	// ------------------------------------------------------------------
	logic [IW_W-1:0]  width_reg  = RST_IMAGE_WIDTH;
	logic [IH_W-1:0]  height_reg = RST_IMAGE_HEIGHT;
	logic [CFG_W-1:0] tmpl_reg [4] = '{RST_TEMPLATES_A, RST_TEMPLATES_B,
	                                   RST_TEMPLATES_C, RST_TEMPLATES_D};
	logic             line_above     [MAX_W] = '{default: 1'b0};
	logic             line_two_above [MAX_W] = '{default: 1'b0};
	logic [8:0]       nbhd = '0;
	int unsigned      in_col = 0, in_row = 0, out_col = 0, out_row = 0;
	bit               frame_closed = 1'b0;

	hom_result_t      expected_q [$];
	hom_result_t      head;
	int unsigned      mismatches = 0;
	int unsigned      pixels_taken = 0;   // requests that were not dropped

	// idle control for both sides, in percent per decision
	int unsigned      src_idle_pct = 0;
	int unsigned      snk_idle_pct = 0;
	bit               long_hold_req = 1'b0;
	int unsigned      hold_left = 0;
	int unsigned      snk_stall = 0;

	function automatic int unsigned eff_width();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_W) return MAX_W;
		return 32'(width_reg);
	endfunction

	function automatic int unsigned eff_height();
		return (height_reg == 0) ? 1 : 32'(height_reg);
	endfunction

	// any template whose cared-for, in-image neighbours all agree
	function automatic logic any_template_hit(logic [8:0] fg, logic [8:0] in_img);
		logic [TPL_W-1:0] t;
		for (int i = 0; i < 8; i++) begin
			t = tmpl_reg[i / 2][(i % 2) * TPL_W +: TPL_W];
			if (((fg ^ t[17:9]) & t[8:0] & in_img) == '0)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// advance the shadow by one accepted request; returns 0 when dropped
	function automatic bit predict_transform(logic [7:0] pix, logic drain);
		int unsigned w, h, col;
		logic        fg, top, mid, emit, last;
		logic [8:0]  in_img;
		hom_result_t r;
		w = eff_width();
		h = eff_height();
		if (in_row < h && drain)
			return 1'b0;
		fg  = (in_row >= h) ? 1'b0 : (pix != 8'd0);
		col = (in_col < MAX_W) ? in_col : 0;
		top = line_two_above[col];
		mid = line_above[col];
		// shift the window left by one column, bring in the new right column
		nbhd = {fg, nbhd[8], nbhd[7], mid, nbhd[5], nbhd[4], top, nbhd[2], nbhd[1]};
		line_two_above[col] = mid;
		line_above[col]     = fg;
		emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
		if (in_col + 1 >= w) begin
			in_col = 0;
			in_row++;
		end else begin
			in_col++;
		end
		if (!emit)
			return 1'b1;
		in_img = '1;
		if (out_row == 0)      in_img &= ~MASK_TOP_ROW;
		if (out_row + 1 >= h)  in_img &= ~MASK_BOT_ROW;
		if (out_col == 0)      in_img &= ~MASK_LEFT_COL;
		if (out_col + 1 >= w)  in_img &= ~MASK_RIGHT_COL;
		last   = (out_row + 1 >= h) && (out_col + 1 >= w);
		r.pix  = any_template_hit(nbhd, in_img) ? PIX_HIT : PIX_MISS;
		r.last = last;
		expected_q.push_back(r);
		if (last) begin
			in_col  = 0;
			in_row  = 0;
			out_col = 0;
			out_row = 0;
			frame_closed = 1'b1;
		end else if (out_col + 1 >= w) begin
			out_col = 0;
			out_row++;
		end else begin
			out_col++;
		end
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Result side: ready with random stall bursts and an on-demand hold
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (long_hold_req) begin
			hold_left     = 400;
			long_hold_req = 1'b0;
		end
		if (hold_left != 0) begin
			// long hold: let the block fill up and push back on its input
			hold_left--;
			m_tready <= 1'b0;
		end else if (snk_stall != 0) begin
			snk_stall--;
			m_tready <= 1'b0;
		end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
			snk_stall = $urandom_range(1, 14) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// compare every accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result %0d last %0b with nothing expected",
					m_tdata, m_tlast));
			end else begin
				head = expected_q.pop_front();
				if (m_tdata !== head.pix)
					report_mismatch($sformatf("out_pixel %0d, expected %0d",
						m_tdata, head.pix));
				if (m_tlast !== head.last)
					report_mismatch($sformatf("frame_end %0b, expected %0b",
						m_tlast, head.last));
			end
		end
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------
	// offer one request, hold it until accepted, then update the shadow
	task automatic send_request(input logic [7:0] pix, input logic drain);
		int unsigned gap;
		gap = 0;
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
			gap = $urandom_range(1, 14);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		s_tuser  <= drain;
		do @(posedge clk); while (!s_tready);
		if (predict_transform(pix, drain))
			pixels_taken++;
	endtask

	// drop valid and wait until every result is back and the pipe is empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// one register write; call only while the block is idle
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_IMAGE_WIDTH:  width_reg  = val[IW_W-1:0];
			REG_IMAGE_HEIGHT: height_reg = val[IH_W-1:0];
			REG_TEMPLATES_A:  tmpl_reg[0] = val;
			REG_TEMPLATES_B:  tmpl_reg[1] = val;
			REG_TEMPLATES_C:  tmpl_reg[2] = val;
			REG_TEMPLATES_D:  tmpl_reg[3] = val;
			default: ;
		endcase
	endtask

	task automatic set_size(input int unsigned w, input int unsigned h);
		write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
	endtask

	// two templates with sparse care bits, so that hits and misses both occur
	function automatic logic [CFG_W-1:0] sparse_template_pair();
		logic [TPL_W-1:0] t [2];
		for (int k = 0; k < 2; k++) begin
			for (int b = 0; b < 9; b++) begin
				t[k][b]     = ($urandom_range(0, 2) == 0);
				t[k][9 + b] = 1'($urandom_range(0, 1));
			end
		end
		return {t[1], t[0]};
	endfunction

	task automatic load_templates(input bit fully_random);
		logic [CFG_W-1:0] v;
		for (int r = 0; r < 4; r++) begin
			v = fully_random ? CFG_W'({$urandom, $urandom}) : sparse_template_pair();
			write_reg(REG_TEMPLATES_A + IDX_W'(r), v);
		end
	endtask

	// one full frame at the current size: pixels, then drains until the
	// frame_end result has been predicted; noise mixes dropped drains into
	// the pixel phase and plain pixels into the drain phase
	task automatic send_frame(input int unsigned fg_pct, input int unsigned noise_pct);
		int unsigned npix;
		npix = eff_width() * eff_height();
		frame_closed = 1'b0;
		for (int unsigned n = 0; n < npix; n++) begin
			if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct)
				send_request(8'($urandom_range(0, 255)), 1'b1);
			send_request(($urandom_range(0, 99) < fg_pct) ?
				8'($urandom_range(1, 255)) : 8'd0, 1'b0);
		end
		while (!frame_closed)
			send_request(8'($urandom_range(0, 255)),
				!(noise_pct != 0 && $urandom_range(0, 99) < noise_pct));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// small frames with the templates left at reset, pixel extremes, a drain
	// dropped in the pixel phase, a pixel standing in for a drain, and a 1x1
	// frame right behind a 3x3 one
	task automatic test_directed_frames();
		logic [7:0] pix_list [9] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h00,
		                            8'h7F, 8'h00, 8'hFE, 8'h55};
		set_size(3, 3);
		frame_closed = 1'b0;
		for (int i = 0; i < 9; i++) begin
			send_request(pix_list[i], 1'b0);
			if (i == 2)
				send_request(8'hC3, 1'b1);
		end
		send_request(8'hAA, 1'b0);
		while (!frame_closed)
			send_request(8'hFF, 1'b1);
		settle();
		set_size(1, 1);
		frame_closed = 1'b0;
		send_request(8'hFF, 1'b0);
		while (!frame_closed)
			send_request(8'h00, 1'b1);
		settle();
	endtask

	// all don't-care templates hit everywhere; all-care all-foreground ones
	// hit only on fully set neighbourhoods; then fully random templates
	task automatic test_template_extremes();
		set_size(5, 4);
		for (int r = 0; r < 4; r++)
			write_reg(REG_TEMPLATES_A + IDX_W'(r), '0);
		send_frame(50, 5);
		settle();
		for (int r = 0; r < 4; r++)
			write_reg(REG_TEMPLATES_A + IDX_W'(r), '1);
		send_frame(90, 5);
		send_frame(100, 0);
		settle();
		load_templates(1'b1);
		send_frame(50, 5);
		settle();
	endtask

	// zero sizes, a tall narrow frame, a wide short one and a single line
	task automatic test_size_extremes();
		load_templates(1'b0);
		set_size(0, 0);
		send_frame(50, 10);
		settle();
		set_size(1, 60);
		send_frame(50, 2);
		settle();
		set_size(30, 2);
		send_frame(40, 2);
		settle();
		set_size(2, 1);
		send_frame(50, 10);
		settle();
	endtask

	// hold the result side for a long stretch while requests keep coming
	task automatic test_backpressure();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		load_templates(1'b0);
		set_size(20, 8);
		long_hold_req = 1'b1;
		send_frame(50, 3);
		settle();
	endtask

	// random sizes, templates, densities and idle rates, frame after frame
	task automatic test_random_frames();
		int unsigned start, pct_pick [3] = '{0, 15, 40};
		start = pixels_taken;
		while (pixels_taken - start < 300) begin
			src_idle_pct = pct_pick[$urandom_range(0, 2)];
			snk_idle_pct = pct_pick[$urandom_range(0, 2)];
			if ($urandom_range(0, 3) == 0)
				load_templates($urandom_range(0, 4) == 0);
			set_size($urandom_range(1, 12), $urandom_range(1, 8));
			repeat ($urandom_range(1, 3))
				send_frame($urandom_range(0, 4) * 25, $urandom_range(0, 8));
			settle();
		end
	endtask

	// back to the reset templates, full rate on both sides
	task automatic test_full_rate();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_reg(REG_TEMPLATES_A, RST_TEMPLATES_A);
		write_reg(REG_TEMPLATES_B, RST_TEMPLATES_B);
		write_reg(REG_TEMPLATES_C, RST_TEMPLATES_C);
		write_reg(REG_TEMPLATES_D, RST_TEMPLATES_D);
		set_size(7, 5);
		repeat (3) send_frame(50, 0);
		settle();
		set_size(1, 6);
		repeat (2) send_frame(50, 0);
		settle();
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle_pct = 20;
		snk_idle_pct = 20;
		test_directed_frames();
		test_template_extremes();
		test_size_extremes();
		test_backpressure();
		test_random_frames();
		test_full_rate();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

endmodule
